>>> hw/rtl/mbs_pkg.sv
// shared widths, codes and command/status types of the feedback queue batch scheduler
`timescale 1ns / 1ps
package mbs_pkg;

  localparam int NUM_PROC_DEF = 20;

  localparam int BURST_W   = 10;
  localparam int QUANT_W   = 10;
  localparam int INDEX_W   = 6;
  localparam int LEVEL_W   = 2;
  localparam int TIME_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [QUANT_W-1:0] FIRST_QUANTUM_RST  = QUANT_W'(8);
  localparam logic [QUANT_W-1:0] SECOND_QUANTUM_RST = QUANT_W'(16);

  localparam logic [LEVEL_W-1:0] LEVEL_RR1  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_RR2  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_FCFS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_QUANTUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_QUANTUM = 2'd1;

  typedef struct packed {
    logic                load;
    logic                step;
    logic                flush;
    logic [LEVEL_W-1:0]  level;
  } mbs_cmd_t;

  typedef struct packed {
    logic last_slot;
    logic finish;
    logic scan_last;
    logic pend_valid;
    logic out_free;
  } mbs_stat_t;

endpackage

>>> hw/rtl/mbs_in_if.sv
// input channel carrying one burst time per transaction
`timescale 1ns / 1ps
interface mbs_in_if;
  logic                       valid;
  logic                       ready;
  logic [mbs_pkg::BURST_W-1:0] burst_time;

  modport source (output valid, output burst_time, input ready);
  modport sink (input valid, input burst_time, output ready);
endinterface

>>> hw/rtl/mbs_out_if.sv
// result channel carrying one finished process per transaction
`timescale 1ns / 1ps
interface mbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbs_pkg::INDEX_W-1:0] process_index;
  logic [mbs_pkg::LEVEL_W-1:0] finish_level;
  logic [mbs_pkg::TIME_W-1:0]  turnaround_time;
  logic [mbs_pkg::TIME_W-1:0]  waiting_time;
  logic                        last_result;

  modport source (output valid, output process_index, output finish_level,
                  output turnaround_time, output waiting_time, output last_result,
                  input ready);
  modport sink (input valid, input process_index, input finish_level,
                input turnaround_time, input waiting_time, input last_result,
                output ready);
endinterface

>>> hw/rtl/mbs_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps
interface mbs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mbs_pkg::CFG_IDX_W-1:0] index;
  logic [mbs_pkg::QUANT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/mbs_ctrl.sv
// scheduler controller: load, three scan levels and final flush
`timescale 1ns / 1ps
module mbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mbs_pkg::mbs_stat_t stat,
  output mbs_pkg::mbs_cmd_t  cmd
);

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_FLUSH} state_t;

  state_t                       state_r, state_nxt;
  logic [mbs_pkg::LEVEL_W-1:0]  level_r, level_nxt;
  logic                         step_ok;

  assign in_ready = (state_r == ST_LOAD);
  assign step_ok  = !(stat.finish && stat.pend_valid) || stat.out_free;

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    cmd       = '0;
    cmd.level = level_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.last_slot) begin
            state_nxt = ST_RUN;
            level_nxt = mbs_pkg::LEVEL_RR1;
          end
        end
      end
      ST_RUN: begin
        cmd.step = step_ok;
        if (step_ok && stat.scan_last) begin
          if (level_r == mbs_pkg::LEVEL_FCFS) begin
            state_nxt = ST_FLUSH;
          end else if (level_r == mbs_pkg::LEVEL_RR1) begin
            level_nxt = mbs_pkg::LEVEL_RR2;
          end else begin
            level_nxt = mbs_pkg::LEVEL_FCFS;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ST_LOAD;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      level_r <= mbs_pkg::LEVEL_RR1;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

>>> hw/rtl/mbs_datapath.sv
// scheduler datapath: burst stores, elapsed time, result holding and output registers
`timescale 1ns / 1ps
module mbs_datapath #(
  parameter int NUM_PROCESSES = mbs_pkg::NUM_PROC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbs_pkg::mbs_cmd_t             cmd,
  output mbs_pkg::mbs_stat_t            stat,
  input  logic [mbs_pkg::BURST_W-1:0]   burst_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbs_pkg::QUANT_W-1:0]   cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mbs_pkg::INDEX_W-1:0]   out_process_index,
  output logic [mbs_pkg::LEVEL_W-1:0]   out_finish_level,
  output logic [mbs_pkg::TIME_W-1:0]    out_turnaround_time,
  output logic [mbs_pkg::TIME_W-1:0]    out_waiting_time,
  output logic                          out_last_result
);

  localparam int IDX_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROCESSES - 1);

  logic [mbs_pkg::BURST_W-1:0] burst_mem_r [NUM_PROCESSES];
  logic [mbs_pkg::BURST_W-1:0] rem_mem_r [NUM_PROCESSES];

  logic [IDX_W-1:0]            load_cnt_r;
  logic [IDX_W-1:0]            idx_r;
  logic [mbs_pkg::TIME_W-1:0]  elapsed_r;
  logic [mbs_pkg::QUANT_W-1:0] first_quantum_r;
  logic [mbs_pkg::QUANT_W-1:0] second_quantum_r;

  logic                        pend_valid_r;
  logic [IDX_W-1:0]            pend_idx_r;
  logic [mbs_pkg::LEVEL_W-1:0] pend_level_r;
  logic [mbs_pkg::TIME_W-1:0]  pend_ta_r;
  logic [mbs_pkg::TIME_W-1:0]  pend_wait_r;

  logic                        out_valid_r;
  logic [mbs_pkg::INDEX_W-1:0] out_idx_r;
  logic [mbs_pkg::LEVEL_W-1:0] out_level_r;
  logic [mbs_pkg::TIME_W-1:0]  out_ta_r;
  logic [mbs_pkg::TIME_W-1:0]  out_wait_r;
  logic                        out_last_r;

  logic [mbs_pkg::BURST_W-1:0] rem;
  logic [mbs_pkg::BURST_W-1:0] burst;
  logic [mbs_pkg::QUANT_W-1:0] slice;
  logic                        finish;
  logic                        run;
  logic                        last_slot;
  logic                        scan_last;
  logic                        out_free;
  logic                        move;
  logic [mbs_pkg::TIME_W-1:0]  elapsed_step;
  logic [mbs_pkg::TIME_W-1:0]  waiting;

  assign rem       = rem_mem_r[idx_r];
  assign burst     = burst_mem_r[idx_r];
  assign slice     = (cmd.level == mbs_pkg::LEVEL_RR1) ? first_quantum_r : second_quantum_r;
  assign finish    = (rem != '0) && ((cmd.level == mbs_pkg::LEVEL_FCFS) || (rem <= slice));
  assign run       = (rem != '0) && !finish;
  assign last_slot = (load_cnt_r == LAST_IDX);
  assign scan_last = (idx_r == LAST_IDX);
  assign out_free  = !out_valid_r || out_ready;
  assign move      = (cmd.step && finish && pend_valid_r) || cmd.flush;

  always_comb begin
    elapsed_step = elapsed_r;
    if (finish) begin
      elapsed_step = elapsed_r + mbs_pkg::TIME_W'(rem);
    end else if (run) begin
      elapsed_step = elapsed_r + mbs_pkg::TIME_W'(slice);
    end
  end

  assign waiting = elapsed_step - mbs_pkg::TIME_W'(burst);

  assign stat.last_slot  = last_slot;
  assign stat.finish     = finish;
  assign stat.scan_last  = scan_last;
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = out_free;

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_process_index   = out_idx_r;
  assign out_finish_level    = out_level_r;
  assign out_turnaround_time = out_ta_r;
  assign out_waiting_time    = out_wait_r;
  assign out_last_result     = out_last_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r       <= '0;
      idx_r            <= '0;
      elapsed_r        <= '0;
      first_quantum_r  <= mbs_pkg::FIRST_QUANTUM_RST;
      second_quantum_r <= mbs_pkg::SECOND_QUANTUM_RST;
      pend_valid_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mbs_pkg::CFG_FIRST_QUANTUM:  first_quantum_r  <= cfg_data;
          mbs_pkg::CFG_SECOND_QUANTUM: second_quantum_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        load_cnt_r <= last_slot ? '0 : load_cnt_r + 1'b1;
        if (last_slot) begin
          elapsed_r <= '0;
          idx_r     <= '0;
        end
      end
      if (cmd.step) begin
        elapsed_r <= elapsed_step;
        idx_r     <= scan_last ? '0 : idx_r + 1'b1;
        if (finish) begin
          pend_valid_r <= 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stores and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      burst_mem_r[load_cnt_r] <= burst_time;
      rem_mem_r[load_cnt_r]   <= burst_time;
    end else if (cmd.step) begin
      if (finish) begin
        rem_mem_r[idx_r] <= '0;
      end else if (run) begin
        rem_mem_r[idx_r] <= rem - slice;
      end
    end
    if (cmd.step && finish) begin
      pend_idx_r   <= idx_r;
      pend_level_r <= cmd.level;
      pend_ta_r    <= elapsed_step;
      pend_wait_r  <= waiting;
    end
    if (move) begin
      out_idx_r   <= mbs_pkg::INDEX_W'(pend_idx_r);
      out_level_r <= pend_level_r;
      out_ta_r    <= pend_ta_r;
      out_wait_r  <= pend_wait_r;
      out_last_r  <= cmd.flush;
    end
  end

  // a held result only moves into a free output register
  a_move_free: assert property (@(posedge clk) disable iff (!rst_n) move |-> out_free)
    else $error("result moved into an occupied output register");

  // a finishing step always leaves a result held
  a_finish_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && finish) |=> pend_valid_r)
    else $error("finished process not held");

  // the flush empties the holding register
  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> !pend_valid_r)
    else $error("holding register not emptied by flush");

  // loading only starts once the previous batch has drained into the output
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !pend_valid_r)
    else $error("load while a result is still held");

endmodule

>>> hw/rtl/mlfq_batch_scheduler_sim.sv
// top level of the multilevel feedback queue batch scheduler
//
// in_ch carries one burst time per transaction and loads the next process slot.
// cfg_ch writes the level 0 slice (index 0) and level 1 slice (index 1); other
// indexes are ignored. cfg_ch is always ready.
// out_ch gives one transaction per finished process in finish order, with
// last_result high on the final one of the batch.
// loading stores one burst time per item, in slot order. the item that fills
// the last slot starts the schedule: three scans over all processes, one per
// level, then the final result is released. in_ch is not ready in the schedule.
// each result waits in a holding register until the next one finishes, so the
// last flag is known; a scan step that finishes a process while another result
// is held waits while the output register is full and not taken, so a stalled
// receiver stalls the scan.
// reset clears the load position, elapsed time and both channels and sets the
// slices to 8 and 16; the burst stores need no clearing.
`timescale 1ns / 1ps
module mlfq_batch_scheduler_sim #(
  parameter int NUM_PROCESSES = mbs_pkg::NUM_PROC_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mbs_in_if.sink       in_ch,
  mbs_out_if.source    out_ch,
  mbs_cfg_if.sink      cfg_ch
);

  mbs_pkg::mbs_cmd_t  cmd;
  mbs_pkg::mbs_stat_t stat;

  mbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbs_datapath #(
    .NUM_PROCESSES (NUM_PROCESSES)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .burst_time          (in_ch.burst_time),
    .cfg_valid           (cfg_ch.valid),
    .cfg_ready           (cfg_ch.ready),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_process_index   (out_ch.process_index),
    .out_finish_level    (out_ch.finish_level),
    .out_turnaround_time (out_ch.turnaround_time),
    .out_waiting_time    (out_ch.waiting_time),
    .out_last_result     (out_ch.last_result)
  );

endmodule
